@@ hw/rtl/bbms_pkg.sv @@
// Shared types, constants and fixed point helpers for the bouncing ball motion step.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package bbms_pkg;

	// Number formats: signed words with FRAC_W fraction bits
	localparam int FRAC_W      = 16;
	localparam int WORD_W      = 24;
	localparam int UWORD_W     = WORD_W - 1;
	localparam int ANGLE_W     = FRAC_W + 9;
	localparam int STEP_TIME_W = 16;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = WORD_W;

	// Step time saturates at 0.05 s halved, i.e. 1/40 s
	localparam int DT_MAX_INT = (1 << FRAC_W) / 40;
	localparam int DT_W       = $clog2(DT_MAX_INT + 1);
	localparam logic [DT_W-1:0] DT_MAX = DT_W'(DT_MAX_INT);

	// Product widths: word times zero-extended step time, floored back to FRAC_W
	localparam int PROD_W   = WORD_W + DT_W + 1;
	localparam int STEP_W   = PROD_W - FRAC_W;
	localparam int SPIN_P_W = WORD_W + DT_W;
	localparam int SPIN_D_W = SPIN_P_W - FRAC_W;

	localparam logic [ANGLE_W-1:0] FULL_TURN = ANGLE_W'(360 << FRAC_W);

	localparam logic [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
	localparam logic [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

	// Register reset values
	localparam int GRAVITY_RST  = -642253;
	localparam int SPIN_RST     = 120 << FRAC_W;
	localparam int WALL_X_RST   = 96518;
	localparam int WALL_Z_RST   = 96518;
	localparam int FLOOR_RST    = -54292;
	localparam int RADIUS_RST   = 16384;
	localparam int BOUNCE_RST   = (9 << FRAC_W) / 2;
	localparam int SOUND_EN_RST = 1;

	// Ball state reset values: resting against the left wall on the floor
	localparam int POS_X_RST = RADIUS_RST - WALL_X_RST;
	localparam int POS_Y_RST = FLOOR_RST + RADIUS_RST;
	localparam int VEL_X_RST = ((1 << FRAC_W) * 8 + 5) / 10;
	localparam int VEL_Y_RST = (9 << FRAC_W) / 2;

	// Queue between front and back; depth is a power of two
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GRAVITY,
		REG_SPIN_RATE,
		REG_WALL_X,
		REG_WALL_Z,
		REG_FLOOR_LEVEL,
		REG_CONTACT_RADIUS,
		REG_BOUNCE_SPEED,
		REG_SOUND_ENABLE
	} cfg_reg_t;

	typedef struct packed {
		logic [WORD_W-1:0]  gravity;
		logic [WORD_W-1:0]  spin_rate;
		logic [UWORD_W-1:0] wall_x;
		logic [UWORD_W-1:0] wall_z;
		logic [WORD_W-1:0]  floor_level;
		logic [UWORD_W-1:0] contact_radius;
		logic [UWORD_W-1:0] bounce_speed;
		logic               sound_enable;
	} cfg_t;

	// Classified tick as it waits in the queue
	typedef struct packed {
		logic                restart;
		logic [DT_W-1:0]     dt;
		logic [STEP_W-1:0]   gdt;
		logic [SPIN_D_W-1:0] spin_d;
	} op_t;

	// Clip a word that grew by one bit back into the signed word range
	function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [WORD_W:0] v);
		if (v[WORD_W] != v[WORD_W-1])
			return v[WORD_W] ? WORD_MIN : WORD_MAX;
		return v[WORD_W-1:0];
	endfunction

	// Negate, clipping the most negative word to the most positive
	function automatic logic signed [WORD_W-1:0] neg_sat(input logic signed [WORD_W-1:0] v);
		if (v == WORD_MIN)
			return WORD_MAX;
		return WORD_W'(~v + WORD_W'(1));
	endfunction

	// Signed word times step time, floored to FRAC_W fraction bits
	function automatic logic signed [STEP_W-1:0] fmul_step(input logic signed [WORD_W-1:0] a,
			input logic [DT_W-1:0] dt);
		logic signed [PROD_W-1:0] p;
		p = a * signed'({1'b0, dt});
		return p[PROD_W-1:FRAC_W];
	endfunction

	// Unsigned spin rate times step time, floored to FRAC_W fraction bits
	function automatic logic [SPIN_D_W-1:0] spin_step(input logic [WORD_W-1:0] r,
			input logic [DT_W-1:0] dt);
		logic [SPIN_P_W-1:0] p;
		p = SPIN_P_W'(r) * SPIN_P_W'(dt);
		return p[SPIN_P_W-1:FRAC_W];
	endfunction

endpackage

@@ hw/rtl/bbms_if.sv @@
// Valid/ready channel interfaces for tick items and result items.
// Depends on bbms_pkg for field widths.
`timescale 1ns / 1ps

interface bbms_tick_if import bbms_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [STEP_TIME_W-1:0] step_time;
	logic                   restart;

	modport source (output valid, output step_time, output restart, input ready);
	modport sink (input valid, input step_time, input restart, output ready);
endinterface

interface bbms_result_if import bbms_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [WORD_W-1:0] out_x;
	logic signed [WORD_W-1:0] out_y;
	logic signed [WORD_W-1:0] out_z;
	logic [ANGLE_W-1:0]       out_angle;
	logic                     floor_sound;
	logic                     wall_sound;

	modport source (output valid, output out_x, output out_y, output out_z,
		output out_angle, output floor_sound, output wall_sound, input ready);
	modport sink (input valid, input out_x, input out_y, input out_z,
		input out_angle, input floor_sound, input wall_sound, output ready);
endinterface

@@ hw/rtl/bbms_front.sv @@
// Front end: accepts tick items, saturates the step time and forms the
// state-independent products (gravity and spin). Depends on bbms_pkg, bbms_if.
`timescale 1ns / 1ps

module bbms_front import bbms_pkg::*; (
	bbms_tick_if.sink tick,
	input  cfg_t      cfg,
	input  logic      q_full,
	output logic      push,
	output op_t       push_op
);

	logic [DT_W-1:0] dt_sat;

	// Accept whenever the queue has room
	assign tick.ready = !q_full;
	assign push       = tick.valid && !q_full;

	// Clip the step time
	assign dt_sat = (tick.step_time > STEP_TIME_W'(DT_MAX)) ? DT_MAX
		: tick.step_time[DT_W-1:0];

	// Classify and precompute; the queue entry is the product register
	always_comb begin
		push_op.restart = tick.restart;
		push_op.dt      = dt_sat;
		push_op.gdt     = fmul_step(cfg.gravity, dt_sat);
		push_op.spin_d  = spin_step(cfg.spin_rate, dt_sat);
	end

endmodule

@@ hw/rtl/bbms_queue.sv @@
// Short FIFO of classified tick items between front and back.
// Depends on bbms_pkg.
`timescale 1ns / 1ps

module bbms_queue import bbms_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  op_t  push_op,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output op_t  head_op
);

	op_t               entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full       = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_op    = entry_q[rd_ptr_q];

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (push && !pop)
				count_q <= count_q + QCNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - QCNT_W'(1);
		end
	end

	// Store items
	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_op;
	end

endmodule

@@ hw/rtl/bbms_back.sv @@
// Back end: holds the ball state, runs one step item through three steps
// (velocity and side products, vertical product, integrate and collide) and
// drives the result output register. Depends on bbms_pkg, bbms_if.
`timescale 1ns / 1ps

module bbms_back import bbms_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  cfg_t            cfg,
	input  logic            head_valid,
	input  op_t             head_op,
	output logic            pop,
	bbms_result_if.source   result
);

	typedef enum logic [1:0] {PH_VEL, PH_VERT, PH_MOVE} phase_t;

	phase_t phase_q;

	// Ball state
	logic signed [WORD_W-1:0] pos_x_q, pos_y_q, pos_z_q;
	logic signed [WORD_W-1:0] vel_x_q, vel_y_q, vel_z_q;
	logic [ANGLE_W-1:0]       angle_q;
	logic                     spin_neg_q;

	// Working registers for the item in flight
	logic [DT_W-1:0]          dt_q;
	logic [SPIN_D_W-1:0]      spin_d_q;
	logic signed [WORD_W-1:0] vel_y_new_q;
	logic signed [STEP_W-1:0] step_x_q, step_y_q, step_z_q;

	// Result register
	logic                     out_valid_q;
	logic signed [WORD_W-1:0] out_x_q, out_y_q, out_z_q;
	logic [ANGLE_W-1:0]       out_angle_q;
	logic                     floor_sound_q, wall_sound_q;

	logic slot_free, start_restart, start_step, finish, load;
	logic signed [WORD_W-1:0] floor_lim, hi_x, lo_x, hi_z, lo_z;
	logic signed [WORD_W-1:0] vel_y_new;
	logic signed [WORD_W:0]   sum_x, sum_y, sum_z;
	logic signed [WORD_W-1:0] mov_x, mov_y, mov_z;
	logic signed [WORD_W-1:0] nxt_pos_x, nxt_pos_y, nxt_pos_z;
	logic signed [WORD_W-1:0] nxt_vel_x, nxt_vel_y, nxt_vel_z;
	logic                     floor_hit, wall_hit;
	logic signed [ANGLE_W:0]  ang_cur, ang_d, ang_sum, ang_full;
	logic [ANGLE_W-1:0]       nxt_angle;

	// Handshake control
	assign slot_free     = !out_valid_q || result.ready;
	assign start_restart = (phase_q == PH_VEL) && head_valid && head_op.restart && slot_free;
	assign start_step    = (phase_q == PH_VEL) && head_valid && !head_op.restart;
	assign finish        = (phase_q == PH_MOVE) && slot_free;
	assign pop           = start_restart || start_step;
	assign load          = start_restart || finish;

	// Contact limits from the registers
	always_comb begin
		floor_lim = sat_word(signed'({cfg.floor_level[WORD_W-1], cfg.floor_level})
			+ signed'({2'b00, cfg.contact_radius}));
		hi_x = sat_word(signed'({2'b00, cfg.wall_x} - {2'b00, cfg.contact_radius}));
		lo_x = sat_word(signed'({2'b00, cfg.contact_radius} - {2'b00, cfg.wall_x}));
		hi_z = sat_word(signed'({2'b00, cfg.wall_z} - {2'b00, cfg.contact_radius}));
		lo_z = sat_word(signed'({2'b00, cfg.contact_radius} - {2'b00, cfg.wall_z}));
	end

	// Apply gravity to the vertical velocity
	assign vel_y_new = sat_word((WORD_W+1)'(vel_y_q) + (WORD_W+1)'(signed'(head_op.gdt)));

	// Integrate positions
	always_comb begin
		sum_x = (WORD_W+1)'(pos_x_q) + (WORD_W+1)'(step_x_q);
		sum_y = (WORD_W+1)'(pos_y_q) + (WORD_W+1)'(step_y_q);
		sum_z = (WORD_W+1)'(pos_z_q) + (WORD_W+1)'(step_z_q);
		mov_x = sat_word(sum_x);
		mov_y = sat_word(sum_y);
		mov_z = sat_word(sum_z);
	end

	// Collide with floor and walls; the upper wall test wins when walls cross
	always_comb begin
		nxt_pos_y = mov_y;
		nxt_vel_y = vel_y_new_q;
		floor_hit = 1'b0;
		if (mov_y < floor_lim) begin
			nxt_pos_y = floor_lim;
			nxt_vel_y = signed'({1'b0, cfg.bounce_speed});
			floor_hit = 1'b1;
		end

		nxt_pos_x = mov_x;
		nxt_vel_x = vel_x_q;
		wall_hit  = 1'b0;
		if (mov_x > hi_x) begin
			nxt_pos_x = hi_x;
			nxt_vel_x = vel_x_q[WORD_W-1] ? vel_x_q : neg_sat(vel_x_q);
			wall_hit  = 1'b1;
		end else if (mov_x < lo_x) begin
			nxt_pos_x = lo_x;
			nxt_vel_x = vel_x_q[WORD_W-1] ? neg_sat(vel_x_q) : vel_x_q;
			wall_hit  = 1'b1;
		end

		nxt_pos_z = mov_z;
		nxt_vel_z = vel_z_q;
		if (mov_z > hi_z) begin
			nxt_pos_z = hi_z;
			nxt_vel_z = vel_z_q[WORD_W-1] ? vel_z_q : neg_sat(vel_z_q);
		end else if (mov_z < lo_z) begin
			nxt_pos_z = lo_z;
			nxt_vel_z = vel_z_q[WORD_W-1] ? neg_sat(vel_z_q) : vel_z_q;
		end
	end

	// Advance the spin angle and wrap it into one turn
	always_comb begin
		ang_cur  = signed'({1'b0, angle_q});
		ang_d    = signed'((ANGLE_W+1)'(spin_d_q));
		ang_full = signed'({1'b0, FULL_TURN});
		ang_sum  = spin_neg_q ? (ang_cur - ang_d) : (ang_cur + ang_d);
		if (ang_sum > ang_full)
			ang_sum = ang_sum - ang_full;
		else if (ang_sum < 0)
			ang_sum = ang_sum + ang_full;
		nxt_angle = ang_sum[ANGLE_W-1:0];
	end

	// Sequencer, ball state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_VEL;
			pos_x_q       <= WORD_W'(POS_X_RST);
			pos_y_q       <= WORD_W'(POS_Y_RST);
			pos_z_q       <= '0;
			vel_x_q       <= WORD_W'(VEL_X_RST);
			vel_y_q       <= WORD_W'(VEL_Y_RST);
			vel_z_q       <= '0;
			angle_q       <= '0;
			spin_neg_q    <= 1'b0;
			out_valid_q   <= 1'b0;
			out_x_q       <= '0;
			out_y_q       <= '0;
			out_z_q       <= '0;
			out_angle_q   <= '0;
			floor_sound_q <= 1'b0;
			wall_sound_q  <= 1'b0;
		end else begin
			case (phase_q)
				PH_VEL: begin
					if (start_restart) begin
						pos_x_q       <= lo_x;
						pos_y_q       <= floor_lim;
						pos_z_q       <= '0;
						out_x_q       <= lo_x;
						out_y_q       <= floor_lim;
						out_z_q       <= '0;
						out_angle_q   <= angle_q;
						floor_sound_q <= 1'b0;
						wall_sound_q  <= 1'b0;
					end else if (start_step) begin
						phase_q <= PH_VERT;
					end
				end
				PH_VERT: begin
					phase_q <= PH_MOVE;
				end
				PH_MOVE: begin
					if (finish) begin
						phase_q       <= PH_VEL;
						pos_x_q       <= nxt_pos_x;
						pos_y_q       <= nxt_pos_y;
						pos_z_q       <= nxt_pos_z;
						vel_x_q       <= nxt_vel_x;
						vel_y_q       <= nxt_vel_y;
						vel_z_q       <= nxt_vel_z;
						angle_q       <= nxt_angle;
						spin_neg_q    <= spin_neg_q ^ wall_hit;
						out_x_q       <= nxt_pos_x;
						out_y_q       <= nxt_pos_y;
						out_z_q       <= nxt_pos_z;
						out_angle_q   <= nxt_angle;
						floor_sound_q <= floor_hit && cfg.sound_enable;
						wall_sound_q  <= wall_hit && cfg.sound_enable;
					end
				end
				default: begin
					phase_q <= PH_VEL;
				end
			endcase

			// Hold the result item until it is taken
			if (load)
				out_valid_q <= 1'b1;
			else if (result.ready)
				out_valid_q <= 1'b0;
		end
	end

	// Working registers: products of the item in flight
	always_ff @(posedge clk) begin
		if (start_step) begin
			dt_q        <= head_op.dt;
			spin_d_q    <= head_op.spin_d;
			vel_y_new_q <= vel_y_new;
			step_x_q    <= fmul_step(vel_x_q, head_op.dt);
			step_z_q    <= fmul_step(vel_z_q, head_op.dt);
		end
		if (phase_q == PH_VERT)
			step_y_q <= fmul_step(vel_y_new_q, dt_q);
	end

	assign result.valid       = out_valid_q;
	assign result.out_x       = out_x_q;
	assign result.out_y       = out_y_q;
	assign result.out_z       = out_z_q;
	assign result.out_angle   = out_angle_q;
	assign result.floor_sound = floor_sound_q;
	assign result.wall_sound  = wall_sound_q;

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		angle_q <= FULL_TURN)
		else $error("spin angle left one turn");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !result.ready) |-> !load)
		else $error("result register loaded while its item is unread");

	a_restart_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		start_restart |=> (!floor_sound_q && !wall_sound_q && out_valid_q))
		else $error("restart item raised a sound flag");

	a_wall_flip: assert property (@(posedge clk) disable iff (!arst_n)
		(finish && wall_hit) |=> (spin_neg_q != $past(spin_neg_q)))
		else $error("X wall hit did not flip spin direction");

endmodule

@@ hw/rtl/bouncing_ball_motion_step.sv @@
// Top level of the bouncing ball motion step: configuration registers,
// front end, item queue and back end. Depends on bbms_pkg, bbms_if and the submodules.
//
// Usage:
//   tick   - valid/ready sink; one item per time tick: step_time (Q0.16 s, clipped
//            to 1/40 s) and restart. An item is taken when valid and ready are high.
//   result - valid/ready source; one item per tick: position, spin angle and the
//            floor and wall sound flags (flags only when sound_enable is set).
//   cfg_we / cfg_index / cfg_data - register writes, one per cycle, no read-back;
//            write only while no item is in flight.
// An accepted step item passes the queue and the PH_VEL, PH_VERT and PH_MOVE phases
// into the result register; a restart item is loaded from PH_VEL. The front end queues
// an item every cycle while the four-entry queue has room. The back end takes a new
// item only when done with the last: the ball state loops through the vertical
// velocity update, its multiply by the step time, and the integrate-and-collide stage.
// When the receiver stalls, the result register holds its item, the back end waits
// with its item in flight, and tick.ready drops once the queue is full.
// Reset loads the register defaults and puts the ball against the left
// wall on the floor with its start velocity; queue and result register empty.
`timescale 1ns / 1ps

module bouncing_ball_motion_step import bbms_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	bbms_tick_if.sink             tick,
	bbms_result_if.source         result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t cfg_q;
	logic q_full, push, pop, head_valid;
	op_t  push_op, head_op;

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gravity        <= WORD_W'(GRAVITY_RST);
			cfg_q.spin_rate      <= WORD_W'(SPIN_RST);
			cfg_q.wall_x         <= UWORD_W'(WALL_X_RST);
			cfg_q.wall_z         <= UWORD_W'(WALL_Z_RST);
			cfg_q.floor_level    <= WORD_W'(FLOOR_RST);
			cfg_q.contact_radius <= UWORD_W'(RADIUS_RST);
			cfg_q.bounce_speed   <= UWORD_W'(BOUNCE_RST);
			cfg_q.sound_enable   <= 1'(SOUND_EN_RST);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_GRAVITY:        cfg_q.gravity        <= cfg_data[WORD_W-1:0];
				REG_SPIN_RATE:      cfg_q.spin_rate      <= cfg_data[WORD_W-1:0];
				REG_WALL_X:         cfg_q.wall_x         <= cfg_data[UWORD_W-1:0];
				REG_WALL_Z:         cfg_q.wall_z         <= cfg_data[UWORD_W-1:0];
				REG_FLOOR_LEVEL:    cfg_q.floor_level    <= cfg_data[WORD_W-1:0];
				REG_CONTACT_RADIUS: cfg_q.contact_radius <= cfg_data[UWORD_W-1:0];
				REG_BOUNCE_SPEED:   cfg_q.bounce_speed   <= cfg_data[UWORD_W-1:0];
				REG_SOUND_ENABLE:   cfg_q.sound_enable   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	bbms_front u_front (
		.tick    (tick),
		.cfg     (cfg_q),
		.q_full  (q_full),
		.push    (push),
		.push_op (push_op)
	);

	bbms_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_op    (push_op),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_op    (head_op)
	);

	bbms_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (head_valid),
		.head_op    (head_op),
		.pop        (pop),
		.result     (result)
	);

endmodule
